// File: rtl/lzf_ring_window_decompressor_unit_assert.svh
// Assertion macros for the decompressor RTL
`ifndef LZF_RING_WINDOW_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZF_RING_WINDOW_DECOMPRESSOR_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset
`define LZFRW_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define LZFRW_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lzfrw_pkg.sv
// Types and constants for the LZF ring window decompressor
package lzfrw_pkg;

  localparam int MAX_WINDOW_DEF = 4096;
  localparam int LANES          = 4;
  localparam int CNT_W          = 3;
  localparam int LANE_W         = $clog2(LANES);
  localparam logic [3:0] WIN_LG_RESET = 4'd12;
  localparam logic [3:0] WIN_LG_MIN   = 4'd8;
  localparam logic [3:0] WIN_LG_MAX   = 4'd12;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_LIT,
    PH_OFF,
    PH_EXT
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0]            count;
    logic [LANES-1:0][7:0]       bytes;
    logic                        run_last;
    logic                        stream_end;
    logic                        corrupt;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

endpackage

// File: rtl/lzfrw_if.sv
// Channel interfaces: compressed byte input and decompressed word output
interface lzfrw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_last;
  modport source (output valid, output data_byte, output stream_last, input ready);
  modport sink (input valid, input data_byte, input stream_last, output ready);
endinterface

interface lzfrw_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_count;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic       run_last;
  logic       stream_end;
  logic       corrupt;
  modport source (output valid, output out_count, output out_byte0, output out_byte1,
                  output out_byte2, output out_byte3, output run_last,
                  output stream_end, output corrupt, input ready);
  modport sink (input valid, input out_count, input out_byte0, input out_byte1,
                input out_byte2, input out_byte3, input run_last,
                input stream_end, input corrupt, output ready);
endinterface

// File: rtl/lzfrw_ram.sv
// Generic simple dual-port RAM with registered read
module lzfrw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port; read data holds while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lzfrw_outreg.sv
// Output register stage driving the result channel
module lzfrw_outreg
  import lzfrw_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  push_t         push,
  output logic          free,
  lzfrw_out_if.source   result
);

  logic hold_valid;
  res_t hold;

  assign free = !hold_valid || result.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (push.valid) begin
      hold_valid <= 1'b1;
    end else if (result.ready) begin
      hold_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push.valid) begin
      hold <= push.res;
    end
  end

  assign result.valid      = hold_valid;
  assign result.out_count  = hold.count;
  assign result.out_byte0  = hold.bytes[0];
  assign result.out_byte1  = hold.bytes[1];
  assign result.out_byte2  = hold.bytes[2];
  assign result.out_byte3  = hold.bytes[3];
  assign result.run_last   = hold.run_last;
  assign result.stream_end = hold.stream_end;
  assign result.corrupt    = hold.corrupt;

endmodule

// File: rtl/lzf_ring_window_decompressor_unit.sv
// Top level: LZF token parser, history copy sequencer and ring RAM
// Takes one compressed byte per word and returns decompressed bytes packed up to four
// to a word, each also stored in a ring history of 2^window_log2 bytes (8..12, capped
// at MAX_WINDOW). A literal byte leaves as a word of one byte. For a backref, every
// copied byte is one history read through the single RAM read port and one
// write back in the ST_WRITE state that follows, so overlapping copies see their
// own output. window_log2 must be written through cfg_wr_en/cfg_wr_data only
// while the block is idle; the block itself does not enforce this.
module lzf_ring_window_decompressor_unit
  import lzfrw_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  lzfrw_in_if.sink    stream,
  lzfrw_out_if.source result
);

  `include "lzf_ring_window_decompressor_unit_assert.svh"

  localparam int AW = $clog2(MAX_WINDOW);

  state_t                     state, state_next;
  phase_t                     phase, phase_next;
  logic [3:0]                 window_lg;
  logic [AW-1:0]              wp, wp_next;
  logic [7:0]                 held_ctrl, held_ctrl_next;
  logic [11:0]                part_off, part_off_next;
  logic [7:0]                 lit_left, lit_left_next;
  logic [7:0]                 cp_left, cp_left_next;
  logic [AW-1:0]              cp_dist, cp_dist_next;
  logic                       cp_last, cp_last_next;
  logic [LANES-1:0][7:0]      pk_bytes, pk_bytes_next;
  logic [LANE_W-1:0]          pk_count, pk_count_next;

  logic [3:0]                 lg_c;
  logic [AW-1:0]              mask, wp_m, wp_inc;
  logic                       out_free, accept;
  push_t                      push;
  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [7:0]                 ram_wdata, ram_rdata;

  logic [7:0]                 b;
  logic [9:0]                 off_s;
  logic [11:0]                off_l;
  logic [12:0]                off_p1;
  logic [7:0]                 len_l;
  logic [CNT_W-1:0]           new_cnt;
  logic                       fin, push_need;
  logic [LANES-1:0][7:0]      lanes_new;
  logic [7:0]                 lit_dec;

  // ring mask from the clamped window size
  always_comb begin
    lg_c = window_lg;
    if (window_lg < WIN_LG_MIN) lg_c = WIN_LG_MIN;
    if (window_lg > WIN_LG_MAX) lg_c = WIN_LG_MAX;
    for (int i = 0; i < AW; i++) begin
      mask[i] = (i < int'(lg_c));
    end
  end

  assign wp_m   = wp & mask;
  assign wp_inc = (wp_m + AW'(1)) & mask;
  assign accept = stream.valid && stream.ready;
  assign stream.ready = (state == ST_IDLE) && out_free;

  // parser and copy sequencer
  always_comb begin
    state_next     = state;
    phase_next     = phase;
    wp_next        = wp;
    held_ctrl_next = held_ctrl;
    part_off_next  = part_off;
    lit_left_next  = lit_left;
    cp_left_next   = cp_left;
    cp_dist_next   = cp_dist;
    cp_last_next   = cp_last;
    pk_bytes_next  = pk_bytes;
    pk_count_next  = pk_count;
    push           = '0;
    ram_we         = 1'b0;
    ram_waddr      = wp_m;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = (wp_m - cp_dist) & mask;

    b       = stream.data_byte;
    off_s   = 10'(held_ctrl[1:0]) + {b, 2'b00};
    off_l   = part_off + {b[7:6], 10'd0};
    off_p1  = 13'd0;
    len_l   = 8'({b[5:0], held_ctrl[2]}) + 8'd2 + ((off_l < 12'd2048) ? 8'd30 : 8'd0);
    lit_dec = lit_left - 8'd1;
    new_cnt = CNT_W'(pk_count) + CNT_W'(1);
    fin     = (cp_left == 8'd1);
    push_need = fin || (new_cnt == CNT_W'(LANES));
    lanes_new = pk_bytes;
    lanes_new[pk_count] = ram_rdata;
    for (int k = 0; k < LANES; k++) begin
      if (k >= int'(new_cnt)) lanes_new[k] = 8'd0;
    end

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (phase)
            PH_CTRL: begin
              if (b[7]) begin
                held_ctrl_next = b;
                phase_next     = PH_OFF;
              end else begin
                lit_left_next = b + 8'd1;
                phase_next    = PH_LIT;
              end
              push.valid          = stream.stream_last;
              push.res.run_last   = 1'b1;
              push.res.stream_end = 1'b1;
              push.res.corrupt    = 1'b1;
            end
            PH_LIT: begin
              ram_we              = 1'b1;
              ram_wdata           = b;
              wp_next             = wp_inc;
              lit_left_next       = lit_dec;
              if (lit_dec == 8'd0) phase_next = PH_CTRL;
              push.valid          = 1'b1;
              push.res.count      = CNT_W'(1);
              push.res.bytes[0]   = b;
              push.res.run_last   = 1'b1;
              push.res.stream_end = stream.stream_last;
              push.res.corrupt    = stream.stream_last && (lit_dec != 8'd0);
            end
            PH_OFF: begin
              if (held_ctrl[7:3] == 5'h1F) begin
                part_off_next       = 12'(off_s);
                phase_next          = PH_EXT;
                push.valid          = stream.stream_last;
                push.res.run_last   = 1'b1;
                push.res.stream_end = 1'b1;
                push.res.corrupt    = 1'b1;
              end else begin
                off_p1       = 13'(off_s) + 13'd1;
                cp_dist_next = off_p1[AW-1:0] & mask;
                cp_left_next = 8'(held_ctrl[6:2]) + 8'd2;
                cp_last_next = stream.stream_last;
                phase_next   = PH_CTRL;
                state_next   = ST_READ;
              end
            end
            PH_EXT: begin
              off_p1       = {1'b0, off_l} + 13'd1;
              cp_dist_next = off_p1[AW-1:0] & mask;
              cp_left_next = len_l;
              cp_last_next = stream.stream_last;
              phase_next   = PH_CTRL;
              state_next   = ST_READ;
            end
            default: phase_next = PH_CTRL;
          endcase
          // end of stream returns the parser to a clean start
          if (stream.stream_last) begin
            phase_next     = PH_CTRL;
            held_ctrl_next = 8'd0;
            part_off_next  = 12'd0;
            lit_left_next  = 8'd0;
          end
        end
      end
      ST_READ: begin
        ram_re     = 1'b1;
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        // write back and pack; wait here if a word is due and cannot leave
        if (!push_need || out_free) begin
          ram_we       = 1'b1;
          wp_next      = wp_inc;
          cp_left_next = cp_left - 8'd1;
          state_next   = fin ? ST_IDLE : ST_READ;
          if (push_need) begin
            push.valid          = 1'b1;
            push.res.count      = new_cnt;
            push.res.bytes      = lanes_new;
            push.res.run_last   = fin;
            push.res.stream_end = fin && cp_last;
            push.res.corrupt    = 1'b0;
            pk_count_next       = '0;
          end else begin
            pk_bytes_next = lanes_new;
            pk_count_next = pk_count + LANE_W'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_CTRL;
      window_lg <= WIN_LG_RESET;
      wp        <= '0;
      held_ctrl <= 8'd0;
      part_off  <= 12'd0;
      lit_left  <= 8'd0;
      cp_left   <= 8'd0;
      pk_count  <= '0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      wp        <= wp_next;
      held_ctrl <= held_ctrl_next;
      part_off  <= part_off_next;
      lit_left  <= lit_left_next;
      cp_left   <= cp_left_next;
      pk_count  <= pk_count_next;
      if (cfg_wr_en) window_lg <= cfg_wr_data;
    end
  end

  // copy payload registers
  always_ff @(posedge clk) begin
    cp_dist  <= cp_dist_next;
    cp_last  <= cp_last_next;
    pk_bytes <= pk_bytes_next;
  end

  lzfrw_ram #(
    .WIDTH (8),
    .DEPTH (MAX_WINDOW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lzfrw_outreg u_out (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .free   (out_free),
    .result (result)
  );

  `LZFRW_ASSERT_NXT(a_read_then_write, clk, rst, state == ST_READ, state == ST_WRITE, "read not followed by write-back")
  `LZFRW_ASSERT_IMP(a_copy_len, clk, rst, state == ST_READ || state == ST_WRITE, cp_left != 8'd0, "copy running with no bytes left")
  `LZFRW_ASSERT_IMP(a_no_write_on_read, clk, rst, ram_we, state != ST_READ, "history write during read cycle")
  `LZFRW_ASSERT_IMP(a_pack_empty_idle, clk, rst, state == ST_IDLE, pk_count == '0, "packed bytes left over between tokens")

endmodule
